@@ hdl/flp3_pkg.sv @@
// Package for the 3D Gaussian low-pass unit.
// Holds the item structs, register indexes and the per-item filter mode.
// No dependencies.
`timescale 1ns / 1ps

package flp3_pkg;

    localparam int COEF_WIDTH = 32;
    localparam int ROOT_W     = 15;
    localparam int QUOT_W     = 20;

    typedef enum logic [2:0] {
        REG_SIZE_X        = 3'd0,
        REG_SIZE_Y        = 3'd1,
        REG_SIZE_Z        = 3'd2,
        REG_CUTOFF_RADIUS = 3'd3,
        REG_SMOOTH_WIDTH  = 3'd4
    } reg_idx_t;

    typedef enum logic [1:0] {
        MODE_PASS  = 2'd0,
        MODE_HARD  = 2'd1,
        MODE_GAUSS = 2'd2
    } mode_t;

    typedef struct packed {
        logic [7:0]                   coord_x;
        logic [7:0]                   coord_y;
        logic [7:0]                   coord_z;
        logic signed [COEF_WIDTH-1:0] coef_re;
        logic signed [COEF_WIDTH-1:0] coef_im;
    } in_t;

    typedef struct packed {
        logic signed [COEF_WIDTH-1:0] out_re;
        logic signed [COEF_WIDTH-1:0] out_im;
        logic                         out_of_range;
    } out_t;

    typedef struct packed {
        logic signed [COEF_WIDTH-1:0] re;
        logic signed [COEF_WIDTH-1:0] im;
        mode_t                        mode;
        logic                         oor;
    } side_t;

endpackage

@@ hdl/flp3_isqrt.sv @@
// Pipelined integer square root, one result bit per stage.
// Carries the item sideband alongside; depends on flp3_pkg.
`timescale 1ns / 1ps

module flp3_isqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [2*flp3_pkg::ROOT_W-1:0] radicand,
    input  flp3_pkg::side_t               in_side,
    output logic                          out_valid,
    output logic [flp3_pkg::ROOT_W-1:0]   root,
    output flp3_pkg::side_t               out_side
);
    import flp3_pkg::*;

    localparam int NS = ROOT_W;

    logic [ROOT_W:0]     rem_reg  [0:NS-1];
    logic [ROOT_W-1:0]   root_reg [0:NS-1];
    logic [2*ROOT_W-1:0] rad_reg  [0:NS-1];
    side_t               side_reg [0:NS-1];
    logic                vld_reg  [0:NS-1];

    genvar i;
    generate
        for (i = 0; i < NS; i++) begin : g_stage
            localparam int K = NS - 1 - i;
            logic [ROOT_W:0]     p_rem;
            logic [ROOT_W-1:0]   p_root;
            logic [2*ROOT_W-1:0] p_rad;
            side_t               p_side;
            logic                p_vld;
            logic [ROOT_W+2:0]   cand;
            logic [ROOT_W+2:0]   trial;
            logic                ge;
            logic [ROOT_W:0]     rem_next;
            logic [ROOT_W-1:0]   root_next;

            if (i == 0) begin : g_first
                assign p_rem  = '0;
                assign p_root = '0;
                assign p_rad  = radicand;
                assign p_side = in_side;
                assign p_vld  = in_valid;
            end else begin : g_rest
                assign p_rem  = rem_reg[i-1];
                assign p_root = root_reg[i-1];
                assign p_rad  = rad_reg[i-1];
                assign p_side = side_reg[i-1];
                assign p_vld  = vld_reg[i-1];
            end

            assign cand      = {p_rem, p_rad[2*K+1 -: 2]};
            assign trial     = {1'b0, p_root, 2'b01};
            assign ge        = (cand >= trial);
            assign rem_next  = ge ? (ROOT_W + 1)'(cand - trial) : cand[ROOT_W:0];
            assign root_next = {p_root[ROOT_W-2:0], ge};

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[i] <= 1'b0;
                end
                else
                begin
                    vld_reg[i] <= p_vld;
                end
            end

            always_ff @(posedge clk)
            begin
                rem_reg[i]  <= rem_next;
                root_reg[i] <= root_next;
                rad_reg[i]  <= p_rad;
                side_reg[i] <= p_side;
            end
        end
    endgenerate

    assign out_valid = vld_reg[NS-1];
    assign root      = root_reg[NS-1];
    assign out_side  = side_reg[NS-1];

endmodule

@@ hdl/flp3_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
// Carries the item sideband alongside; depends on flp3_pkg.
`timescale 1ns / 1ps

module flp3_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic [31:0]                 rem_init,
    input  logic [3:0]                  low_bits,
    input  logic [31:0]                 divisor,
    input  flp3_pkg::side_t             in_side,
    output logic                        out_valid,
    output logic [flp3_pkg::QUOT_W-1:0] quot,
    output flp3_pkg::side_t             out_side
);
    import flp3_pkg::*;

    localparam int NS = QUOT_W;

    logic [31:0]       rem_reg  [0:NS-1];
    logic [QUOT_W-1:0] quot_reg [0:NS-1];
    logic [3:0]        low_reg  [0:NS-1];
    side_t             side_reg [0:NS-1];
    logic              vld_reg  [0:NS-1];

    genvar i;
    generate
        for (i = 0; i < NS; i++) begin : g_stage
            logic [31:0]       p_rem;
            logic [QUOT_W-1:0] p_quot;
            logic [3:0]        p_low;
            side_t             p_side;
            logic              p_vld;
            logic              nbit;
            logic [32:0]       cand;
            logic              ge;
            logic [31:0]       rem_next;

            if (i == 0) begin : g_first
                assign p_rem  = rem_init;
                assign p_quot = '0;
                assign p_low  = low_bits;
                assign p_side = in_side;
                assign p_vld  = in_valid;
            end else begin : g_rest
                assign p_rem  = rem_reg[i-1];
                assign p_quot = quot_reg[i-1];
                assign p_low  = low_reg[i-1];
                assign p_side = side_reg[i-1];
                assign p_vld  = vld_reg[i-1];
            end

            if (i < 4) begin : g_num
                assign nbit = p_low[3-i];
            end else begin : g_zero
                assign nbit = 1'b0;
            end

            assign cand     = {p_rem, nbit};
            assign ge       = (cand >= {1'b0, divisor});
            assign rem_next = ge ? 32'(cand - {1'b0, divisor}) : cand[31:0];

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[i] <= 1'b0;
                end
                else
                begin
                    vld_reg[i] <= p_vld;
                end
            end

            always_ff @(posedge clk)
            begin
                rem_reg[i]  <= rem_next;
                quot_reg[i] <= {p_quot[QUOT_W-2:0], ge};
                low_reg[i]  <= p_low;
                side_reg[i] <= p_side;
            end
        end
    endgenerate

    assign out_valid = vld_reg[NS-1];
    assign quot      = quot_reg[NS-1];
    assign out_side  = side_reg[NS-1];

endmodule

@@ hdl/fourier_gaussian_lowpass_3d_unit.sv @@
// Top level of the 3D Gaussian low-pass unit for half-stored spectra.
// Depends on flp3_pkg, flp3_isqrt and flp3_div.
//
//  Channel   Handshake            Payload
//  item in   start (busy low)     coef   : flp3_pkg::in_t
//  item out  done, one cycle      result : flp3_pkg::out_t
//  config    cfg_wr               cfg_idx, cfg_wdata
//
// One item is accepted every cycle. The pipeline runs through stages A to D, the
// square root (15 stages), stages E to G, the divider (20 stages), stages H to K,
// the ten squaring stages of the exponential and stages L and M. Reset clears the
// registers to their defaults and empties the pipeline. Busy stays low, and the
// receiver cannot stall.
`timescale 1ns / 1ps

module fourier_gaussian_lowpass_3d_unit #(
    parameter int MAX_DIM = 256
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  flp3_pkg::in_t   coef,
    output logic            done,
    output flp3_pkg::out_t  result,
    input  logic            cfg_wr,
    input  logic [2:0]      cfg_idx,
    input  logic [15:0]     cfg_wdata
);
    import flp3_pkg::*;

    localparam int          CW      = COEF_WIDTH;
    localparam int          LIM_INT = (MAX_DIM > 511) ? 511 : MAX_DIM;
    localparam logic [8:0]  DIM_LIM = 9'(LIM_INT);
    localparam int          NSQ     = 10;

    logic [8:0]  size_x_reg, size_y_reg, size_z_reg;
    logic [15:0] radius_reg, smooth_reg;
    logic [31:0] rad2_reg, s2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_x_reg <= 9'd256;
            size_y_reg <= 9'd256;
            size_z_reg <= 9'd256;
            radius_reg <= 16'd0;
            smooth_reg <= 16'd0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_SIZE_X:        size_x_reg <= cfg_wdata[8:0];
                REG_SIZE_Y:        size_y_reg <= cfg_wdata[8:0];
                REG_SIZE_Z:        size_z_reg <= cfg_wdata[8:0];
                REG_CUTOFF_RADIUS: radius_reg <= cfg_wdata;
                REG_SMOOTH_WIDTH:  smooth_reg <= cfg_wdata;
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        rad2_reg <= radius_reg * radius_reg;
        s2_reg   <= smooth_reg * smooth_reg;
    end

    assign busy = 1'b0;

    // Stage A: input capture.
    logic a_v_reg;
    in_t  a_reg;

    // Stage B: range check and folding.
    logic       b_v_reg;
    logic [7:0] b_fx_reg, b_fy_reg, b_fz_reg;
    side_t      b_side_reg;

    // Stage C: squared distance.
    logic        c_v_reg;
    logic [17:0] c_d2_reg;
    side_t       c_side_reg;

    // Stage D: radius compare and mode.
    logic        d_v_reg;
    logic [29:0] d_v30_reg;
    side_t       d_side_reg;

    logic [8:0] sx, sy, sz;
    logic       oor_next;
    logic [7:0] fy_next, fz_next;
    logic [17:0] d2_next;
    logic        outside;
    mode_t       mode_next;

    assign sx = (size_x_reg > DIM_LIM) ? DIM_LIM : size_x_reg;
    assign sy = (size_y_reg > DIM_LIM) ? DIM_LIM : size_y_reg;
    assign sz = (size_z_reg > DIM_LIM) ? DIM_LIM : size_z_reg;

    assign oor_next = (a_reg.coord_x > sx[8:1]) || ({1'b0, a_reg.coord_y} >= sy)
                   || ({1'b0, a_reg.coord_z} >= sz);
    assign fy_next  = (a_reg.coord_y <= sy[8:1]) ? a_reg.coord_y
                    : 8'(sy - {1'b0, a_reg.coord_y});
    assign fz_next  = (a_reg.coord_z <= sz[8:1]) ? a_reg.coord_z
                    : 8'(sz - {1'b0, a_reg.coord_z});

    assign d2_next = 18'(b_fx_reg * b_fx_reg) + 18'(b_fy_reg * b_fy_reg)
                   + 18'(b_fz_reg * b_fz_reg);

    assign outside = ({2'b00, c_d2_reg, 12'd0} > rad2_reg);

    always_comb
    begin
        if (c_side_reg.oor || !outside)
            mode_next = MODE_PASS;
        else if (smooth_reg == 16'd0)
            mode_next = MODE_HARD;
        else
            mode_next = MODE_GAUSS;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
            d_v_reg <= 1'b0;
        end
        else
        begin
            a_v_reg <= start && !busy;
            b_v_reg <= a_v_reg;
            c_v_reg <= b_v_reg;
            d_v_reg <= c_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg           <= coef;
        b_fx_reg        <= a_reg.coord_x;
        b_fy_reg        <= fy_next;
        b_fz_reg        <= fz_next;
        b_side_reg.re   <= a_reg.coef_re;
        b_side_reg.im   <= a_reg.coef_im;
        b_side_reg.mode <= MODE_PASS;
        b_side_reg.oor  <= oor_next;
        c_d2_reg        <= d2_next;
        c_side_reg      <= b_side_reg;
        d_v30_reg       <= {c_d2_reg, 12'd0};
        d_side_reg.re   <= c_side_reg.re;
        d_side_reg.im   <= c_side_reg.im;
        d_side_reg.oor  <= c_side_reg.oor;
        d_side_reg.mode <= mode_next;
    end

    logic                sq_v;
    logic [ROOT_W-1:0]   sq_root;
    side_t               sq_side;

    flp3_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (d_v_reg),
        .radicand  (d_v30_reg),
        .in_side   (d_side_reg),
        .out_valid (sq_v),
        .root      (sq_root),
        .out_side  (sq_side)
    );

    // Stage E: excess over the radius. Stage F: its square.
    // Stage G: overflow test of the Gaussian argument.
    logic              e_v_reg, f_v_reg, g_v_reg;
    logic [ROOT_W-1:0] e_reg;
    logic [29:0]       f_e2_reg;
    logic [29:0]       g_e2_reg;
    side_t             e_side_reg, f_side_reg, g_side_reg;
    side_t             g_side_next;
    logic              ovf;

    assign ovf = ({6'd0, f_e2_reg} >= {s2_reg, 4'd0});

    always_comb
    begin
        g_side_next = f_side_reg;
        if (ovf && f_side_reg.mode == MODE_GAUSS)
            g_side_next.mode = MODE_HARD;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_v_reg <= 1'b0;
            f_v_reg <= 1'b0;
            g_v_reg <= 1'b0;
        end
        else
        begin
            e_v_reg <= sq_v;
            f_v_reg <= e_v_reg;
            g_v_reg <= f_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        e_reg      <= ROOT_W'({1'b0, sq_root} - radius_reg);
        e_side_reg <= sq_side;
        f_e2_reg   <= e_reg * e_reg;
        f_side_reg <= e_side_reg;
        g_e2_reg   <= f_e2_reg;
        g_side_reg <= g_side_next;
    end

    logic              dv_v;
    logic [QUOT_W-1:0] dv_t;
    side_t             dv_side;

    flp3_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (g_v_reg),
        .rem_init  ({6'd0, g_e2_reg[29:4]}),
        .low_bits  (g_e2_reg[3:0]),
        .divisor   (s2_reg),
        .in_side   (g_side_reg),
        .out_valid (dv_v),
        .quot      (dv_t),
        .out_side  (dv_side)
    );

    // Stages H to K: cubic start value of the exponential.
    logic        h_v_reg, i_v_reg, j_v_reg, k_v_reg;
    logic [25:0] h_r_reg, i_r_reg, j_r_reg;
    logic [19:0] h_r2_reg, i_r2_reg, j_r2_reg;
    logic [13:0] i_r3_reg;
    logic [11:0] j_q6_reg;
    logic [31:0] k_y_reg;
    side_t       h_side_reg, i_side_reg, j_side_reg, k_side_reg;
    side_t       h_side_next;
    logic [25:0] r_next;
    logic [51:0] rr_next;
    logic [45:0] r3_full;
    logic [27:0] q6_full;
    logic [32:0] y_next;

    assign r_next  = {dv_t, 6'd0};
    assign rr_next = r_next * r_next;
    assign r3_full = h_r2_reg * h_r_reg;
    assign q6_full = i_r3_reg * 14'd10923;
    assign y_next  = 33'h1_0000_0000 - {7'd0, j_r_reg} + {14'd0, j_r2_reg[19:1]}
                   - {21'd0, j_q6_reg};

    always_comb
    begin
        h_side_next = dv_side;
        if (dv_t == '0 && dv_side.mode == MODE_GAUSS)
            h_side_next.mode = MODE_PASS;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_v_reg <= 1'b0;
            i_v_reg <= 1'b0;
            j_v_reg <= 1'b0;
            k_v_reg <= 1'b0;
        end
        else
        begin
            h_v_reg <= dv_v;
            i_v_reg <= h_v_reg;
            j_v_reg <= i_v_reg;
            k_v_reg <= j_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        h_r_reg    <= r_next;
        h_r2_reg   <= rr_next[51:32];
        h_side_reg <= h_side_next;
        i_r_reg    <= h_r_reg;
        i_r2_reg   <= h_r2_reg;
        i_r3_reg   <= r3_full[45:32];
        i_side_reg <= h_side_reg;
        j_r_reg    <= i_r_reg;
        j_r2_reg   <= i_r2_reg;
        j_q6_reg   <= q6_full[27:16];
        j_side_reg <= i_side_reg;
        k_y_reg    <= y_next[31:0];
        k_side_reg <= j_side_reg;
    end

    // Ten squaring stages raise the start value to the power 1024.
    logic [31:0] sqr_y_reg    [0:NSQ-1];
    side_t       sqr_side_reg [0:NSQ-1];
    logic        sqr_v_reg    [0:NSQ-1];

    genvar n;
    generate
        for (n = 0; n < NSQ; n++) begin : g_square
            logic [31:0] p_y;
            side_t       p_side;
            logic        p_v;
            logic [63:0] yy;

            if (n == 0) begin : g_first
                assign p_y    = k_y_reg;
                assign p_side = k_side_reg;
                assign p_v    = k_v_reg;
            end else begin : g_rest
                assign p_y    = sqr_y_reg[n-1];
                assign p_side = sqr_side_reg[n-1];
                assign p_v    = sqr_v_reg[n-1];
            end

            assign yy = p_y * p_y;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    sqr_v_reg[n] <= 1'b0;
                end
                else
                begin
                    sqr_v_reg[n] <= p_v;
                end
            end

            always_ff @(posedge clk)
            begin
                sqr_y_reg[n]    <= yy[63:32];
                sqr_side_reg[n] <= p_side;
            end
        end
    endgenerate

    // Stage L: factor select. Stage M: scaling and output.
    logic        l_v_reg;
    logic [16:0] l_f_reg;
    side_t       l_side_reg;
    logic [16:0] f_next;
    logic [32:0] y_round;
    logic signed [CW+17:0] p_re, p_im;
    logic        done_reg;
    out_t        result_reg;

    assign y_round = {1'b0, sqr_y_reg[NSQ-1]} + 33'd32768;

    always_comb
    begin
        case (sqr_side_reg[NSQ-1].mode)
            MODE_PASS:  f_next = 17'h10000;
            MODE_GAUSS: f_next = y_round[32:16];
            default:    f_next = 17'd0;
        endcase
    end

    assign p_re = l_side_reg.re * $signed({1'b0, l_f_reg});
    assign p_im = l_side_reg.im * $signed({1'b0, l_f_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            l_v_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            l_v_reg  <= sqr_v_reg[NSQ-1];
            done_reg <= l_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        l_f_reg                 <= f_next;
        l_side_reg              <= sqr_side_reg[NSQ-1];
        result_reg.out_re       <= p_re[CW+15:16];
        result_reg.out_im       <= p_im[CW+15:16];
        result_reg.out_of_range <= l_side_reg.oor;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

@@ test/tb_fourier_gaussian_lowpass_3d_unit.sv @@
// Testbench for the 3D Gaussian low-pass unit: directed and random items under
// several register settings, each result checked against a built-in predictor.
// Depends on flp3_pkg and fourier_gaussian_lowpass_3d_unit.
`timescale 1ns / 1ps

module tb_fourier_gaussian_lowpass_3d_unit;
    import flp3_pkg::*;

    localparam int LATENCY = 58;

    logic clk;
    logic rst_n;
    logic start = 1'b0;
    logic busy;
    in_t coef = '0;
    logic done;
    out_t result;
    logic cfg_wr;
    logic [2:0] cfg_idx;
    logic [15:0] cfg_wdata;

    fourier_gaussian_lowpass_3d_unit dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .coef(coef),
        .done(done), .result(result), .cfg_wr(cfg_wr), .cfg_idx(cfg_idx),
        .cfg_wdata(cfg_wdata)
    );

    logic [8:0] sz_x, sz_y, sz_z;
    logic [15:0] radius, smooth;

    in_t pending_items[$];
    out_t expected_results[$];
    int errors = 0;
    bit sender_hold;
    int burst_left = 5;
    int gap_left = 0;

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic logic [31:0] isqrt64(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res[31:0];
    endfunction

    function automatic logic [16:0] rolloff_gain(logic [63:0] t);
        logic [63:0] r, r2, r3, y;
        if (t == 0)
            return 17'd65536;
        if (t >= (64'd16 << 16))
            return 17'd0;
        r = t << 6;
        r2 = (r * r) >> 32;
        r3 = (r2 * r) >> 32;
        y = (64'd1 << 32) - r + (r2 >> 1) - (r3 / 6);
        for (int i = 0; i < 10; i++)
            y = (y * y) >> 32;
        return 17'((y + 32768) >> 16);
    endfunction

    function automatic logic signed [31:0] apply_gain(logic signed [31:0] c, logic [16:0] g);
        logic signed [63:0] prod;
        prod = 64'(c) * $signed({47'd0, g});
        return prod[47:16];
    endfunction

    function automatic out_t filter_coef(in_t it);
        out_t o;
        logic [8:0] sx, sy, sz;
        logic [31:0] fy, fz, dq;
        logic [63:0] d2, e, t;
        logic [16:0] g;
        sx = (sz_x > 256) ? 9'd256 : sz_x;
        sy = (sz_y > 256) ? 9'd256 : sz_y;
        sz = (sz_z > 256) ? 9'd256 : sz_z;
        o.out_re = it.coef_re;
        o.out_im = it.coef_im;
        o.out_of_range = 1'b0;
        if (it.coord_x > sx / 2 || it.coord_y >= sy || it.coord_z >= sz)
        begin
            o.out_of_range = 1'b1;
            return o;
        end
        fy = 32'((it.coord_y <= sy / 2) ? 9'(it.coord_y) : 9'(sy - it.coord_y));
        fz = 32'((it.coord_z <= sz / 2) ? 9'(it.coord_z) : 9'(sz - it.coord_z));
        d2 = 64'(it.coord_x) * it.coord_x + 64'(fy) * fy + 64'(fz) * fz;
        if ((d2 << 12) <= 64'(radius) * radius)
            return o;
        if (smooth == 0)
        begin
            o.out_re = '0;
            o.out_im = '0;
            return o;
        end
        dq = isqrt64(d2 << 12);
        e = 64'(dq) - radius;
        t = ((e * e) << 16) / (64'(smooth) * smooth);
        g = rolloff_gain(t);
        o.out_re = apply_gain(it.coef_re, g);
        o.out_im = apply_gain(it.coef_im, g);
        return o;
    endfunction

    always @(posedge clk)
    begin
        if (start && !busy)
        begin
            expected_results.push_back(filter_coef(coef));
        end
        if (!sender_hold && pending_items.size() > 0 && gap_left == 0
            && !(start && !busy && burst_left == 1))
        begin
            if (!(start && busy))
            begin
                if (start && !busy)
                    void'(pending_items.pop_front());
                if (pending_items.size() > 0)
                begin
                    start <= 1'b1;
                    coef <= pending_items[0];
                    if (start && !busy)
                        burst_left <= burst_left - 1;
                end
                else
                    start <= 1'b0;
            end
        end
        else
        begin
            if (start && !busy)
            begin
                void'(pending_items.pop_front());
                if (burst_left == 1)
                begin
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    burst_left <= $urandom_range(1, 20);
                end
            end
            else if (gap_left > 0)
                gap_left <= gap_left - 1;
            start <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result %h", $time, result);
            end
            else
            begin
                out_t exp_r;
                exp_r = expected_results.pop_front();
                if (result.out_re !== exp_r.out_re)
                begin
                    errors++;
                    $display("%0t: out_re expected %h actual %h", $time, exp_r.out_re,
                             result.out_re);
                end
                if (result.out_im !== exp_r.out_im)
                begin
                    errors++;
                    $display("%0t: out_im expected %h actual %h", $time, exp_r.out_im,
                             result.out_im);
                end
                if (result.out_of_range !== exp_r.out_of_range)
                begin
                    errors++;
                    $display("%0t: out_of_range expected %b actual %b", $time,
                             exp_r.out_of_range, result.out_of_range);
                end
            end
        end
    end

    task automatic write_reg(reg_idx_t idx, logic [15:0] val);
        @(posedge clk);
        cfg_wr <= 1'b1;
        cfg_idx <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_wr <= 1'b0;
        case (idx)
            REG_SIZE_X: sz_x = val[8:0];
            REG_SIZE_Y: sz_y = val[8:0];
            REG_SIZE_Z: sz_z = val[8:0];
            REG_CUTOFF_RADIUS: radius = val;
            REG_SMOOTH_WIDTH: smooth = val;
            default: ;
        endcase
    endtask

    task automatic drain;
        while (pending_items.size() > 0 || start)
            @(posedge clk);
        while (expected_results.size() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic in_t make_item(int mode);
        in_t it;
        int hx, hy, hz;
        hx = ((sz_x > 256) ? 256 : sz_x) / 2;
        hy = (sz_y > 256) ? 256 : sz_y;
        hz = (sz_z > 256) ? 256 : sz_z;
        it.coef_re = $urandom;
        it.coef_im = $urandom;
        if ($urandom_range(0, 7) == 0)
            it.coef_re = ($urandom_range(0, 1) != 0) ? 32'sh80000000 : 32'sh7fffffff;
        if (mode == 0 || hx > 255 || hy == 0 || hz == 0)
        begin
            it.coord_x = 8'($urandom);
            it.coord_y = 8'($urandom);
            it.coord_z = 8'($urandom);
        end
        else
        begin
            it.coord_x = 8'($urandom_range(0, (hx > 255) ? 255 : hx));
            it.coord_y = 8'($urandom_range(0, (hy > 256 ? 256 : hy) - 1));
            it.coord_z = 8'($urandom_range(0, (hz > 256 ? 256 : hz) - 1));
        end
        return it;
    endfunction

    task automatic add_directed(int x, int y, int z, logic [31:0] re, logic [31:0] im);
        in_t it;
        it.coord_x = 8'(x);
        it.coord_y = 8'(y);
        it.coord_z = 8'(z);
        it.coef_re = re;
        it.coef_im = im;
        pending_items.push_back(it);
    endtask

    initial
    begin
        logic [15:0] cfgs[8][5];
        int per_phase;
        rst_n = 1'b0;
        cfg_wr = 1'b0;
        cfg_idx = REG_SIZE_X;
        cfg_wdata = '0;
        sender_hold = 1'b0;
        sz_x = 256;
        sz_y = 256;
        sz_z = 256;
        radius = 0;
        smooth = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_directed(0, 0, 0, 32'h7fffffff, 32'h80000000);
        add_directed(128, 255, 255, 32'h80000000, 32'h7fffffff);
        add_directed(129, 0, 0, 32'h12345678, 32'hffffffff);
        add_directed(5, 128, 3, 32'hffffffff, 32'h00000001);
        drain();

        write_reg(REG_SIZE_X, 16'd64);
        write_reg(REG_SIZE_Y, 16'd48);
        write_reg(REG_SIZE_Z, 16'd33);
        write_reg(REG_CUTOFF_RADIUS, 16'd640);
        write_reg(REG_SMOOTH_WIDTH, 16'd320);
        add_directed(0, 0, 0, 32'h7fffffff, 32'h80000000);
        add_directed(32, 24, 16, 32'h80000000, 32'h7fffffff);
        add_directed(33, 0, 0, 32'h1, 32'h2);
        add_directed(0, 48, 0, 32'h1, 32'h2);
        add_directed(0, 0, 33, 32'h1, 32'h2);
        add_directed(10, 47, 32, 32'hdeadbeef, 32'h0badf00d);
        add_directed(11, 0, 0, 32'h40000000, 32'hc0000000);
        add_directed(20, 20, 10, 32'hffffffff, 32'h00010000);
        add_directed(255, 255, 255, 32'h0, 32'h0);
        drain();
        write_reg(reg_idx_t'(3'd7), 16'hffff);
        write_reg(reg_idx_t'(3'd5), 16'hffff);
        add_directed(1, 1, 1, 32'h5, 32'h6);
        drain();

        cfgs[0] = '{16'h1ff, 16'h1ff, 16'h1ff, 16'hffff, 16'hffff};
        cfgs[1] = '{16'd2, 16'd1, 16'd1, 16'd0, 16'd0};
        cfgs[2] = '{16'd256, 16'd256, 16'd256, 16'd0, 16'd1};
        cfgs[3] = '{16'd200, 16'd100, 16'd77, 16'd1500, 16'd0};
        cfgs[4] = '{16'd128, 16'd256, 16'd64, 16'd2000, 16'd64};
        cfgs[5] = '{16'd0, 16'd0, 16'd0, 16'd100, 16'd100};
        cfgs[6] = '{16'd256, 16'd255, 16'd129, 16'd4000, 16'hffff};
        cfgs[7] = '{16'd90, 16'd256, 16'd256, 16'd3000, 16'd900};
        per_phase = 175;
        for (int p = 0; p < 8; p++)
        begin
            for (int r = 0; r < 5; r++)
                write_reg(reg_idx_t'(r), cfgs[p][r]);
            for (int n = 0; n < per_phase; n++)
            begin
                pending_items.push_back(make_item(($urandom_range(0, 9) == 0) ? 0 : 1));
                if (n == per_phase / 2 && p == 3)
                begin
                    while (pending_items.size() > 0 || start)
                        @(posedge clk);
                    sender_hold = 1'b1;
                    while (expected_results.size() > 0)
                        @(posedge clk);
                    sender_hold = 1'b0;
                end
            end
            drain();
        end

        repeat (LATENCY + 10) @(posedge clk);
        if (errors == 0 && expected_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/flp3_pkg.sv
hdl/flp3_isqrt.sv
hdl/flp3_div.sv
hdl/fourier_gaussian_lowpass_3d_unit.sv
test/tb_fourier_gaussian_lowpass_3d_unit.sv
